// File: src/saaf_pkg.sv
// ----------------------------------------------------------------------------
// saaf_pkg
// shared types and constants for the aperture archive filter
// ----------------------------------------------------------------------------
package saaf_pkg;

  localparam int TimeW   = 63;
  localparam int ValueW  = 32;
  localparam int GroupW  = 9;
  localparam int AperW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  // d * 25600 and base * aperture both fit in this width
  localparam int ProdW   = ValueW + AperW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_IS_DISCRETE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADAPTIVE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FINE_APER   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COARSE_APER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOW_LIMIT   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HIGH_LIMIT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OWN_GROUP   = 3'd6;

  typedef struct packed {
    logic                     is_discrete;
    logic                     adaptive_mode;
    logic [AperW-1:0]         fine_aperture;
    logic [AperW-1:0]         coarse_aperture;
    logic [ValueW-1:0]        span;        // |high_limit - low_limit|
    logic signed [GroupW-1:0] own_group;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]         timestamp;
    logic                     valid_in;
    logic signed [ValueW-1:0] sample_value;
    logic signed [GroupW-1:0] due_group;
  } item_t;

  typedef struct packed {
    logic                     seen_first;
    logic                     valid_flag;
    logic signed [ValueW-1:0] stored_value;
  } hist_t;

  typedef struct packed {
    logic archive;
    logic validity_changed;
    logic fine_exceeded;
    logic coarse_exceeded;
    logic auto_point;
  } flags_t;

endpackage

// File: src/saaf_cfg_regs.sv
// ----------------------------------------------------------------------------
// saaf_cfg_regs
// configuration register file, with the limit span held precomputed
// ----------------------------------------------------------------------------
module saaf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [saaf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [saaf_pkg::CfgDataW-1:0]  cfg_data,
  output saaf_pkg::cfg_t                 cfg
);
  import saaf_pkg::*;

  logic signed [ValueW-1:0] low_limit;
  logic signed [ValueW-1:0] high_limit;
  logic signed [ValueW:0]   span_diff;
  logic [ValueW-1:0]        span_next;

  // span is registered from the limits and follows them in the next cycle
  always_comb begin
    span_diff = {high_limit[ValueW-1], high_limit} - {low_limit[ValueW-1], low_limit};
    if (span_diff[ValueW]) begin
      span_next = ValueW'(-span_diff);
    end else begin
      span_next = span_diff[ValueW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_discrete     <= 1'b0;
      cfg.adaptive_mode   <= 1'b0;
      cfg.fine_aperture   <= '0;
      cfg.coarse_aperture <= '0;
      cfg.own_group       <= '1;
      cfg.span            <= '0;
      low_limit           <= '0;
      high_limit          <= '0;
    end else begin
      cfg.span <= span_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_IS_DISCRETE: cfg.is_discrete     <= cfg_data[0];
          REG_ADAPTIVE:    cfg.adaptive_mode   <= cfg_data[0];
          REG_FINE_APER:   cfg.fine_aperture   <= cfg_data[AperW-1:0];
          REG_COARSE_APER: cfg.coarse_aperture <= cfg_data[AperW-1:0];
          REG_LOW_LIMIT:   low_limit           <= cfg_data[ValueW-1:0];
          REG_HIGH_LIMIT:  high_limit          <= cfg_data[ValueW-1:0];
          REG_OWN_GROUP:   cfg.own_group       <= cfg_data[GroupW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: src/saaf_decide.sv
// ----------------------------------------------------------------------------
// saaf_decide
// archiving reasons for one sample against the stored history
// ----------------------------------------------------------------------------
module saaf_decide (
  input  saaf_pkg::cfg_t   cfg,
  input  saaf_pkg::item_t  item,
  input  saaf_pkg::hist_t  hist,
  output saaf_pkg::flags_t flags
);
  import saaf_pkg::*;

  logic signed [ValueW:0] diff;
  logic [ValueW-1:0]      dmag;
  logic [ValueW-1:0]      stored_mag;
  logic [ValueW-1:0]      base;
  logic [ProdW-1:0]       lhs;
  logic [ProdW-1:0]       fine_lim;
  logic [ProdW-1:0]       coarse_lim;
  logic                   vchg;
  logic                   test_on;

  always_comb begin
    diff = {item.sample_value[ValueW-1], item.sample_value}
         - {hist.stored_value[ValueW-1], hist.stored_value};
    dmag = diff[ValueW] ? ValueW'(-diff) : diff[ValueW-1:0];
    stored_mag = hist.stored_value[ValueW-1] ? ValueW'(-hist.stored_value)
                                             : hist.stored_value;
    base = cfg.adaptive_mode ? stored_mag : cfg.span;

    // d * 25600 as shifts: 16384 + 8192 + 1024
    lhs = (ProdW'(dmag) << 14) + (ProdW'(dmag) << 13) + (ProdW'(dmag) << 10);
    fine_lim   = ProdW'(base) * ProdW'(cfg.fine_aperture);
    coarse_lim = ProdW'(base) * ProdW'(cfg.coarse_aperture);

    vchg    = !hist.seen_first || (item.valid_in != hist.valid_flag);
    test_on = !vchg && item.valid_in;

    flags.validity_changed = vchg;
    flags.fine_exceeded    = test_on && !cfg.is_discrete && (lhs > fine_lim);
    if (cfg.is_discrete) begin
      flags.coarse_exceeded = test_on && (item.sample_value != hist.stored_value);
    end else begin
      flags.coarse_exceeded = test_on && (lhs > coarse_lim);
    end
    flags.auto_point = !cfg.own_group[GroupW-1] && (item.due_group == cfg.own_group);
    flags.archive    = flags.validity_changed | flags.fine_exceeded
                     | flags.coarse_exceeded | flags.auto_point;
  end

endmodule

// File: src/signal_aperture_archive_filter.sv
// ----------------------------------------------------------------------------
// signal_aperture_archive_filter
// per-signal archive filter with fine and coarse deadbands
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  input     in_valid / in_ready    timestamp, valid_in, sample_value, due_group
//  result    res_valid / res_ready  archive, out_time, out_value, out_valid,
//                                   validity_changed, fine_exceeded,
//                                   coarse_exceeded, auto_point
//  config    cfg_wr_en              cfg_index, cfg_data (write only)
//
//  one beat in, one beat out; a beat passes the input register, then the result register
//  a beat every cycle unless res_ready stalls: the history (seen, validity,
//  stored value) updates in the same edge that loads the result register, so the
//  next sample in the input register already compares against it
//  the compare path is one subtract, one 32x16 multiply per aperture and a compare
//  a stalled result holds; one more input beat is taken into the input register
//  synchronous reset clears history, config and both valid flags; own_group resets to all ones
//  limit writes pass the low and high limit registers before reaching the span register
// ----------------------------------------------------------------------------
module signal_aperture_archive_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  // config
  input  logic                                 cfg_wr_en,
  input  logic [saaf_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [saaf_pkg::CfgDataW-1:0]        cfg_data,
  // input beat
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [saaf_pkg::TimeW-1:0]           timestamp,
  input  logic                                 valid_in,
  input  logic signed [saaf_pkg::ValueW-1:0]   sample_value,
  input  logic signed [saaf_pkg::GroupW-1:0]   due_group,
  // result beat
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 archive,
  output logic [saaf_pkg::TimeW-1:0]           out_time,
  output logic signed [saaf_pkg::ValueW-1:0]   out_value,
  output logic                                 out_valid,
  output logic                                 validity_changed,
  output logic                                 fine_exceeded,
  output logic                                 coarse_exceeded,
  output logic                                 auto_point
);
  import saaf_pkg::*;

  cfg_t   cfg;
  item_t  item;
  logic   item_full;
  hist_t  hist;
  flags_t flags;
  logic   res_free;
  logic   advance;

  saaf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result slot is free, or being emptied this cycle
  assign res_free = !res_valid || res_ready;
  assign advance  = item_full && res_free;
  assign in_ready = !item_full || res_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_ready) begin
      item_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.timestamp    <= timestamp;
      item.valid_in     <= valid_in;
      item.sample_value <= sample_value;
      item.due_group    <= due_group;
    end
  end

  saaf_decide u_decide (
    .cfg   (cfg),
    .item  (item),
    .hist  (hist),
    .flags (flags)
  );

  // history moves with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hist.seen_first   <= 1'b0;
      hist.valid_flag   <= 1'b0;
      hist.stored_value <= '0;
    end else if (advance) begin
      if (flags.validity_changed) begin
        hist.seen_first <= 1'b1;
        hist.valid_flag <= item.valid_in;
      end
      if (flags.archive) begin
        hist.stored_value <= item.sample_value;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= item_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      archive          <= flags.archive;
      out_time         <= item.timestamp;
      out_value        <= item.sample_value;
      out_valid        <= item.valid_in;
      validity_changed <= flags.validity_changed;
      fine_exceeded    <= flags.fine_exceeded;
      coarse_exceeded  <= flags.coarse_exceeded;
      auto_point       <= flags.auto_point;
    end
  end

endmodule

// File: src/saaf_checker.sv
// ----------------------------------------------------------------------------
// saaf_checker
// port level checks on the archive filter result beats
// ----------------------------------------------------------------------------
module saaf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic                               archive,
  input logic [saaf_pkg::TimeW-1:0]         out_time,
  input logic                               out_valid,
  input logic                               validity_changed,
  input logic                               fine_exceeded,
  input logic                               coarse_exceeded,
  input logic                               auto_point
);
  import saaf_pkg::*;

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_time) && $stable(archive))
    else $error("stalled result changed");

  // archive is exactly the union of the reasons
  a_archive_or: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> archive == (validity_changed || fine_exceeded
                              || coarse_exceeded || auto_point))
    else $error("archive does not match reasons");

  // deadband tests only run on a valid sample with unchanged validity
  a_test_gate: assert property (@(posedge clk) disable iff (rst)
    res_valid && (fine_exceeded || coarse_exceeded) |-> out_valid && !validity_changed)
    else $error("deadband reason without a valid steady sample");

endmodule

bind signal_aperture_archive_filter saaf_checker u_saaf_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res_valid),
  .res_ready        (res_ready),
  .archive          (archive),
  .out_time         (out_time),
  .out_valid        (out_valid),
  .validity_changed (validity_changed),
  .fine_exceeded    (fine_exceeded),
  .coarse_exceeded  (coarse_exceeded),
  .auto_point       (auto_point)
);
